// ===== design/assert_macros.svh =====
// Assertion macros used by the priority queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held
`define SPQ_ASSERT(label, clock, rstn, prop) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) \
    else $error("priority queue check failed");
// Clocked check that is also evaluated during reset
`define SPQ_ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) (prop)) \
    else $error("priority queue check failed");
`else
`define SPQ_ASSERT(label, clock, rstn, prop)
`define SPQ_ASSERT_ALWAYS(label, clock, prop)
`endif
`endif

// ===== design/spq_pkg.sv =====
// Types, codes and constants of the sorted priority queue
package spq_pkg;

  localparam int PRIO_BITS    = 16;
  localparam int DATA_BITS    = 32;
  localparam int OCC_BITS     = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef struct packed {
    spq_op_t                       operation;
    logic signed [PRIO_BITS-1:0]   item_priority;
    logic signed [DATA_BITS-1:0]   item_value;
  } spq_in_t;

  typedef struct packed {
    spq_status_t                   status;
    logic signed [DATA_BITS-1:0]   removed_value;
    logic                          head_valid;
    logic signed [DATA_BITS-1:0]   head_value;
    logic signed [PRIO_BITS-1:0]   head_priority;
    logic [OCC_BITS-1:0]           occupancy;
  } spq_out_t;

  // One stored entry
  typedef struct packed {
    logic signed [PRIO_BITS-1:0]   prio;
    logic signed [DATA_BITS-1:0]   value;
  } spq_slot_t;

  // Broadcast to every cell in the cycle of a transfer
  typedef struct packed {
    logic                          ins;
    logic                          rem;
    spq_slot_t                     item;
  } spq_ctl_t;

endpackage

// ===== design/sorted_priority_queue.sv =====
// Top level of the sorted priority queue built as a chain of slot cells
//
//   channel  ports                  transfer
//   in       start, busy, in_item   start high while busy low
//   out      out_valid, out_result  every cycle out_valid is high
//
// One item per clock while busy is low; the result shows in the cycle after its transfer, for one cycle.
// Each cell compares against the newcomer in parallel, so the insert position and
// the shift of the whole row settle in the same cycle.
// busy is high during reset and until a clock edge samples rst_n high; synchronous reset
// empties the queue.
// The receiver cannot stall, so nothing is held back on the output side.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::spq_in_t   in_item,
  output logic               out_valid,
  output spq_pkg::spq_out_t  out_result
);
  import spq_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [CW-1:0]          count_r, count_nxt;
  logic                   busy_r;
  logic                   out_valid_r;
  spq_status_t            status_r, status_nxt;
  logic signed [DATA_BITS-1:0] removed_r, removed_nxt;

  logic                   accept;
  spq_ctl_t               ctl;
  logic                   ge    [CAPACITY];
  spq_slot_t              slots [CAPACITY];

  assign accept         = start && !busy_r;
  assign ctl.ins        = accept && (in_item.operation == OP_INSERT) && (count_r != CAP);
  assign ctl.rem        = accept && (in_item.operation == OP_REMOVE) && (count_r != '0);
  assign ctl.item.prio  = in_item.item_priority;
  assign ctl.item.value = in_item.item_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic      lge;
    spq_slot_t lslot, rslot;
    if (i == 0) begin : g_first
      assign lge   = 1'b1;
      assign lslot = ctl.item;
    end else begin : g_mid
      assign lge   = ge[i-1];
      assign lslot = slots[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rslot = slots[i];
    end else begin : g_inner
      assign rslot = slots[i+1];
    end
    spq_cell #(
      .CAPACITY (CAPACITY),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .left_ge    (lge),
      .left_slot  (lslot),
      .right_slot (rslot),
      .ge         (ge[i]),
      .slot       (slots[i])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    if (in_item.operation == OP_INSERT) begin
      if (count_r == CAP) status_nxt = ST_FULL;
    end else begin
      if (count_r == '0) status_nxt = ST_EMPTY;
    end
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem) begin
      count_nxt   = count_r - CW'(1);
      removed_nxt = slots[0].value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= 1'b0;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  // Head cell already holds the state left by the last transfer
  assign busy                     = busy_r;
  assign out_valid                = out_valid_r;
  assign out_result.status        = status_r;
  assign out_result.removed_value = removed_r;
  assign out_result.head_valid    = (count_r != '0);
  assign out_result.head_value    = (count_r != '0) ? slots[0].value : '0;
  assign out_result.head_priority = (count_r != '0) ? slots[0].prio  : '0;
  assign out_result.occupancy     = OCC_BITS'(count_r);

  `SPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CAP)
  `SPQ_ASSERT(a_strobe_follows, clk, rst_n, accept |=> out_valid_r)
  `SPQ_ASSERT(a_no_spurious, clk, rst_n, !accept |=> !out_valid_r)
  `SPQ_ASSERT(a_ins_grows, clk, rst_n, ctl.ins |=> count_r == $past(count_r) + CW'(1))
  `SPQ_ASSERT(a_full_drop, clk, rst_n,
    (out_valid_r && status_r == ST_FULL) |-> count_r == CAP)

endmodule

// ===== design/spq_cell.sv =====
// One slot of the sorted chain: keep, take the new entry, or shift
module spq_cell #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic                                clk,
  input  spq_pkg::spq_ctl_t                   ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]       count,
  input  logic                                left_ge,
  input  spq_pkg::spq_slot_t                  left_slot,
  input  spq_pkg::spq_slot_t                  right_slot,
  output logic                                ge,
  output spq_pkg::spq_slot_t                  slot
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] IDX = CW'(CELL_IDX);

  spq_slot_t slot_r, slot_nxt;
  logic      occupied;

  assign occupied = IDX < count;
  // Held entry stays ahead of the newcomer on equal priority
  assign ge       = occupied && !(slot_r.prio < ctl.item.prio);
  assign slot     = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.ins) begin
      if (!ge) begin
        slot_nxt = left_ge ? ctl.item : left_slot;
      end
    end else if (ctl.rem) begin
      slot_nxt = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule
